/* design/dq0_pkg.sv */
// Shared widths, constants, control types and saturation helper for the dq0 transform.
`timescale 1ns / 1ps

package dq0_pkg;

    // Sample and trigonometric formats (signed Q1.(W-1)).
    localparam int SAMPLE_W = 16;
    localparam int TRIG_W   = 16;

    // Operation codes carried by the operation bit of each item.
    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    // Q2.14 transform constants.
    localparam int CONST_W = 16;
    localparam logic signed [CONST_W-1:0] K_SQRT_2OVER3    = 16'sd13378;
    localparam logic signed [CONST_W-1:0] K_SQRT_1OVER2    = 16'sd11585;
    localparam logic signed [CONST_W-1:0] K_SQRT_1OVER3    = 16'sd9459;
    localparam logic signed [CONST_W-1:0] K_2X_SQRT_1OVER2 = 16'sd23170;
    localparam logic signed [CONST_W-1:0] K_2X_SQRT_1OVER3 = 16'sd18918;

    // Number of register stages in each datapath lane.
    localparam int NUM_STAGES = 4;

    // Derived internal widths.
    localparam int SUM_W   = SAMPLE_W + 2;            // phase sums, alpha and beta
    localparam int MPROD_W = SUM_W + CONST_W;         // products with a Q2.14 constant
    localparam int WIDE_W  = MPROD_W + 2;             // widest accumulation before saturation

    // Per-stage load enables handed from the pipeline control to the lanes.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    localparam logic signed [WIDE_W-1:0] SAT_MAX =
        {{(WIDE_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_MIN =
        {{(WIDE_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    // Clamp a wide signed value to the signed sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [WIDE_W-1:0] x);
        logic signed [SAMPLE_W-1:0] y;
        if (x > SAT_MAX) begin
            y = SAT_MAX[SAMPLE_W-1:0];
        end else if (x < SAT_MIN) begin
            y = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            y = x[SAMPLE_W-1:0];
        end
        return y;
    endfunction

endpackage

/* design/dq0_fwd_lane.sv */
// Forward datapath lane: phase values to d, q and zero in four register stages.
`timescale 1ns / 1ps

module dq0_fwd_lane
    import dq0_pkg::*;
(
    input  logic                       i_clk,
    input  t_pipe_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_u,
    input  logic signed [SAMPLE_W-1:0] i_v,
    input  logic signed [SAMPLE_W-1:0] i_w,
    input  logic signed [TRIG_W-1:0]   i_sine,
    input  logic signed [TRIG_W-1:0]   i_cosine,
    output logic signed [SAMPLE_W-1:0] o_d,
    output logic signed [SAMPLE_W-1:0] o_q,
    output logic signed [SAMPLE_W-1:0] o_zero
);

    localparam int TPROD_W = SUM_W + TRIG_W;
    localparam int TR_W    = SUM_W + 1;
    localparam logic signed [MPROD_W-1:0] HALF_15 = MPROD_W'(1) << 14;
    localparam logic signed [MPROD_W-1:0] HALF_14 = MPROD_W'(1) << 13;
    localparam logic signed [TPROD_W-1:0] HALF_T  = TPROD_W'(1) << (TRIG_W - 2);

    // Stage 1 registers: Clarke sums, angle delayed.
    logic signed [SUM_W-1:0]  r_s1, r_s2, r_s3;
    logic signed [TRIG_W-1:0] r_sin1, r_cos1;
    // Stage 2 registers: alpha, beta and saturated zero.
    logic signed [SUM_W-1:0]    r_alpha, r_beta;
    logic signed [SAMPLE_W-1:0] r_zero2;
    logic signed [TRIG_W-1:0]   r_sin2, r_cos2;
    // Stage 3 registers: rounded rotation products.
    logic signed [TR_W-1:0]     r_ac, r_bs, r_bc, r_as;
    logic signed [SAMPLE_W-1:0] r_zero3;
    // Stage 4 registers: results.
    logic signed [SAMPLE_W-1:0] r_d, r_q, r_zero4;

    logic signed [SUM_W-1:0]   w_u_x, w_v_x, w_w_x;
    logic signed [MPROD_W-1:0] w_p_alpha, w_p_beta, w_p_zero;
    logic signed [TPROD_W-1:0] w_p_ac, w_p_bs, w_p_bc, w_p_as;
    logic signed [TR_W:0]      w_d_sum, w_q_sum;

    // Sign-extend the phase values for the sums.
    assign w_u_x = {{2{i_u[SAMPLE_W-1]}}, i_u};
    assign w_v_x = {{2{i_v[SAMPLE_W-1]}}, i_v};
    assign w_w_x = {{2{i_w[SAMPLE_W-1]}}, i_w};

    // Stage 1: sums that feed alpha, beta and the zero component.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s1   <= (w_u_x <<< 1) - w_v_x - w_w_x;
            r_s2   <= w_v_x - w_w_x;
            r_s3   <= w_u_x + w_v_x + w_w_x;
            r_sin1 <= i_sine;
            r_cos1 <= i_cosine;
        end
    end

    // Stage 2: constant scaling with round half up.
    assign w_p_alpha = r_s1 * K_SQRT_2OVER3 + HALF_15;
    assign w_p_beta  = r_s2 * K_SQRT_1OVER2 + HALF_14;
    assign w_p_zero  = (r_s3 * K_SQRT_1OVER3 + HALF_14) >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_alpha <= w_p_alpha[15 +: SUM_W];
            r_beta  <= w_p_beta[14 +: SUM_W];
            r_zero2 <= sat_sample(WIDE_W'(w_p_zero));
            r_sin2  <= r_sin1;
            r_cos2  <= r_cos1;
        end
    end

    // Stage 3: Park rotation products, each rounded on its own.
    assign w_p_ac = r_alpha * r_cos2 + HALF_T;
    assign w_p_bs = r_beta * r_sin2 + HALF_T;
    assign w_p_bc = r_beta * r_cos2 + HALF_T;
    assign w_p_as = r_alpha * r_sin2 + HALF_T;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_ac    <= w_p_ac[(TRIG_W-1) +: TR_W];
            r_bs    <= w_p_bs[(TRIG_W-1) +: TR_W];
            r_bc    <= w_p_bc[(TRIG_W-1) +: TR_W];
            r_as    <= w_p_as[(TRIG_W-1) +: TR_W];
            r_zero3 <= r_zero2;
        end
    end

    // Stage 4: combine and saturate d and q.
    assign w_d_sum = (TR_W+1)'(r_ac) + (TR_W+1)'(r_bs);
    assign w_q_sum = (TR_W+1)'(r_bc) - (TR_W+1)'(r_as);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_d     <= sat_sample(WIDE_W'(w_d_sum));
            r_q     <= sat_sample(WIDE_W'(w_q_sum));
            r_zero4 <= r_zero3;
        end
    end

    assign o_d    = r_d;
    assign o_q    = r_q;
    assign o_zero = r_zero4;

endmodule

/* design/dq0_inv_lane.sv */
// Inverse datapath lane: d, q and zero back to phase values in four register stages.
`timescale 1ns / 1ps

module dq0_inv_lane
    import dq0_pkg::*;
(
    input  logic                       i_clk,
    input  t_pipe_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_d,
    input  logic signed [SAMPLE_W-1:0] i_q,
    input  logic signed [SAMPLE_W-1:0] i_zero,
    input  logic signed [TRIG_W-1:0]   i_sine,
    input  logic signed [TRIG_W-1:0]   i_cosine,
    output logic signed [SAMPLE_W-1:0] o_u,
    output logic signed [SAMPLE_W-1:0] o_v,
    output logic signed [SAMPLE_W-1:0] o_w
);

    localparam int TPROD_W = SAMPLE_W + TRIG_W;
    localparam int RI_W    = SAMPLE_W + 1;
    localparam logic signed [TPROD_W-1:0] HALF_T  = TPROD_W'(1) << (TRIG_W - 2);
    localparam logic signed [WIDE_W-1:0]  HALF_15 = WIDE_W'(1) << 14;

    // Stage 1 registers: rounded rotation products.
    logic signed [RI_W-1:0]     r_dc, r_qs, r_ds, r_qc;
    logic signed [SAMPLE_W-1:0] r_z1;
    // Stage 2 registers: alpha and beta.
    logic signed [SUM_W-1:0]    r_alpha, r_beta;
    logic signed [SAMPLE_W-1:0] r_z2;
    // Stage 3 registers: products with the Clarke constants.
    logic signed [MPROD_W-1:0]  r_ma, r_mb, r_mz;
    // Stage 4 registers: results.
    logic signed [SAMPLE_W-1:0] r_u, r_v, r_w;

    logic signed [TPROD_W-1:0] w_p_dc, w_p_qs, w_p_ds, w_p_qc;
    logic signed [WIDE_W-1:0]  w_ma, w_mb, w_mz;
    logic signed [WIDE_W-1:0]  w_u_sum, w_v_sum, w_w_sum;

    // Stage 1: inverse Park products, each rounded on its own.
    assign w_p_dc = i_d * i_cosine + HALF_T;
    assign w_p_qs = i_q * i_sine + HALF_T;
    assign w_p_ds = i_d * i_sine + HALF_T;
    assign w_p_qc = i_q * i_cosine + HALF_T;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_dc <= w_p_dc[(TRIG_W-1) +: RI_W];
            r_qs <= w_p_qs[(TRIG_W-1) +: RI_W];
            r_ds <= w_p_ds[(TRIG_W-1) +: RI_W];
            r_qc <= w_p_qc[(TRIG_W-1) +: RI_W];
            r_z1 <= i_zero;
        end
    end

    // Stage 2: alpha and beta.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_alpha <= SUM_W'(r_dc) - SUM_W'(r_qs);
            r_beta  <= SUM_W'(r_ds) + SUM_W'(r_qc);
            r_z2    <= r_z1;
        end
    end

    // Stage 3: multiply by the Clarke constants.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_ma <= r_alpha * K_SQRT_2OVER3;
            r_mb <= r_beta * K_2X_SQRT_1OVER2;
            r_mz <= MPROD_W'(r_z2) * K_2X_SQRT_1OVER3;
        end
    end

    // Stage 4: combine, round half up and saturate.
    assign w_ma    = WIDE_W'(r_ma);
    assign w_mb    = WIDE_W'(r_mb);
    assign w_mz    = WIDE_W'(r_mz);
    assign w_u_sum = ((w_ma <<< 1) + w_mz + HALF_15) >>> 15;
    assign w_v_sum = (w_mb - w_ma + w_mz + HALF_15) >>> 15;
    assign w_w_sum = (w_mz - w_ma - w_mb + HALF_15) >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_u <= sat_sample(w_u_sum);
            r_v <= sat_sample(w_v_sum);
            r_w <= sat_sample(w_w_sum);
        end
    end

    assign o_u = r_u;
    assign o_v = r_v;
    assign o_w = r_w;

endmodule

/* design/three_phase_dq0_transform_unit.sv */
// Top level of the three-phase dq0 transform: pipeline control, lanes and result select.
`timescale 1ns / 1ps

// Power-invariant Clarke plus Park transform on Q1.15 samples, forward (u, v, w to
// d, q, zero) or inverse (d, q, zero to u, v, w) per item, with saturated Q1.15 results.
// o_out_valid rises once an accepted item has passed through the four register stages
// of each datapath lane. While the output is ready a new item is accepted in every
// cycle, so the sustained rate is one item per clock. Both lanes run in lockstep and
// the operation bit selects the result at the output register. Each stage holds its
// item when the stage after it is full and cannot move on, so o_in_ready follows
// i_out_ready combinationally through the valid bits of the four stages.
module three_phase_dq0_transform_unit
    import dq0_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_operation,
    input  logic signed [SAMPLE_W-1:0] i_first_in,
    input  logic signed [SAMPLE_W-1:0] i_second_in,
    input  logic signed [SAMPLE_W-1:0] i_third_in,
    input  logic signed [TRIG_W-1:0]   i_angle_sine,
    input  logic signed [TRIG_W-1:0]   i_angle_cosine,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_first_out,
    output logic signed [SAMPLE_W-1:0] o_second_out,
    output logic signed [SAMPLE_W-1:0] o_third_out
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] r_op;
    logic [NUM_STAGES-1:0] w_en;
    t_pipe_ctl             w_ctl;
    logic                  w_sel_inv;

    logic signed [SAMPLE_W-1:0] w_fwd_d, w_fwd_q, w_fwd_zero;
    logic signed [SAMPLE_W-1:0] w_inv_u, w_inv_v, w_inv_w;

    // A stage loads when it is empty or its item moves on in the same cycle.
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign w_ctl.en   = w_en;
    assign o_in_ready = w_en[0];

    // Valid bits travel with the item through the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // The operation bit follows its item to pick the lane at the output.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_op[0] <= i_operation;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_op[k] <= r_op[k-1];
            end
        end
    end

    dq0_fwd_lane u_fwd (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_u      (i_first_in),
        .i_v      (i_second_in),
        .i_w      (i_third_in),
        .i_sine   (i_angle_sine),
        .i_cosine (i_angle_cosine),
        .o_d      (w_fwd_d),
        .o_q      (w_fwd_q),
        .o_zero   (w_fwd_zero)
    );

    dq0_inv_lane u_inv (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_d      (i_first_in),
        .i_q      (i_second_in),
        .i_zero   (i_third_in),
        .i_sine   (i_angle_sine),
        .i_cosine (i_angle_cosine),
        .o_u      (w_inv_u),
        .o_v      (w_inv_v),
        .o_w      (w_inv_w)
    );

    // Result select from the lanes' output registers.
    assign w_sel_inv    = (r_op[NUM_STAGES-1] == OP_INVERSE);
    assign o_out_valid  = r_vld[NUM_STAGES-1];
    assign o_first_out  = w_sel_inv ? w_inv_u : w_fwd_d;
    assign o_second_out = w_sel_inv ? w_inv_v : w_fwd_q;
    assign o_third_out  = w_sel_inv ? w_inv_w : w_fwd_zero;

    // A free output stage lets the whole pipeline advance, so intake is open.
    a_free_out_opens_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("intake closed while the output stage is free");

    // A full pipeline facing a stalled output takes no new item.
    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_vld == {NUM_STAGES{1'b1}}) && !i_out_ready) |-> !o_in_ready)
        else $error("item accepted into a full stalled pipeline");

    // An accepted item occupies the first stage in the next cycle.
    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted item lost at the first stage");

endmodule
